// ===== sv/pwf_pkg.sv =====
`default_nettype none
package pwf_pkg;

  localparam int unsigned COEF_W     = 32;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIZE_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  // Q16.16 numerators against a Q4.28 denominator: scale the numerator by 2^12.
  localparam int unsigned FRAC_SHIFT = 12;

  localparam int unsigned DEF_MAX_SRC_WIDTH  = 512;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 512;
  localparam int unsigned DEF_MAX_DST_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_DST_HEIGHT = 1024;

  localparam logic [COEF_W-1:0] RESET_COEF_I = 32'h1000_0000;
  localparam logic [SIZE_W-1:0] RESET_SIZE   = 10'd512;
  localparam logic [PIX_W-1:0]  RESET_FILL   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_AB  = 3'd0,
    REG_COEF_CD  = 3'd1,
    REG_COEF_EF  = 3'd2,
    REG_COEF_GH  = 3'd3,
    REG_COEF_I   = 3'd4,
    REG_SRC_W    = 3'd5,
    REG_SRC_H    = 3'd6,
    REG_FILL     = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_WARP  = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/pwf_ram.sv =====
`default_nettype none
module pwf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/perspective_warp_fixed_frame_unit.sv =====
// Pipeline: input capture, coefficient products, projective sums, divider chain, and a
//   registered bounds check with frame store read, in that order.
// Throughput: one word per cycle; the divider is a chain of restoring stages, one bit each.
// Write words take the same path and reach the frame store in order with the warps.
// Reset clears configuration to its defaults and the pipeline valid bits; the frame
//   store is not cleared. The receiver cannot stall, so busy stays low.
`default_nettype none
module perspective_warp_fixed_frame_unit #(
  parameter int unsigned MAX_SRC_WIDTH  = pwf_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = pwf_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_DST_WIDTH  = pwf_pkg::DEF_MAX_DST_WIDTH,
  parameter int unsigned MAX_DST_HEIGHT = pwf_pkg::DEF_MAX_DST_HEIGHT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire                             cmd,
  input  wire [pwf_pkg::COORD_W-1:0]      col,
  input  wire [pwf_pkg::COORD_W-1:0]      row,
  input  wire [pwf_pkg::PIX_W-1:0]        pixel_in,
  output logic                            strobe,
  output logic [pwf_pkg::PIX_W-1:0]       pixel_out,
  output logic                            inside_res,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [pwf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [pwf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pwf_pkg::*;

  localparam int unsigned MAXS  = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH
                                                                   : MAX_SRC_HEIGHT;
  localparam int unsigned QB    = $clog2(MAXS + 1);
  localparam int unsigned NS    = QB + 1;
  localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = COEF_W + COORD_W + 1;
  localparam int unsigned NW    = PW + 2;
  localparam int unsigned MW    = NW;
  localparam int unsigned RW    = MW + FRAC_SHIFT + QB;
  localparam int unsigned LAT   = QB + 6;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] coef_ab, coef_cd, coef_ef, coef_gh;
  logic [COEF_W-1:0]     coef_i;
  logic [SIZE_W-1:0]     src_w, src_h;
  logic [PIX_W-1:0]      fill;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ab <= '0;
      coef_cd <= '0;
      coef_ef <= '0;
      coef_gh <= '0;
      coef_i  <= RESET_COEF_I;
      src_w   <= RESET_SIZE;
      src_h   <= RESET_SIZE;
      fill    <= RESET_FILL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_AB: coef_ab <= cfg_data;
        REG_COEF_CD: coef_cd <= cfg_data;
        REG_COEF_EF: coef_ef <= cfg_data;
        REG_COEF_GH: coef_gh <= cfg_data;
        REG_COEF_I:  coef_i  <= cfg_data[COEF_W-1:0];
        REG_SRC_W:   src_w   <= cfg_data[SIZE_W-1:0];
        REG_SRC_H:   src_h   <= cfg_data[SIZE_W-1:0];
        REG_FILL:    fill    <= cfg_data[PIX_W-1:0];
      endcase
    end
  end

  // Stage 0: input capture.
  logic               s0_v, s0_cmd;
  logic [COORD_W-1:0] s0_col, s0_row;
  logic [PIX_W-1:0]   s0_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_cmd <= cmd;
    s0_col <= col;
    s0_row <= row;
    s0_pix <= pixel_in;
  end

  // Stage 1: the six coefficient products.
  logic                 s1_v, s1_cmd, s1_dok, s1_wok;
  logic [AW-1:0]        s1_waddr;
  logic [PIX_W-1:0]     s1_pix;
  logic signed [PW-1:0] pa, pb, pd, pe, pg, ph;
  logic signed [COORD_W:0] xs, ys;

  assign xs = $signed({1'b0, s0_col});
  assign ys = $signed({1'b0, s0_row});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd   <= s0_cmd;
    s1_dok   <= (32'(s0_col) < 32'(MAX_DST_WIDTH)) && (32'(s0_row) < 32'(MAX_DST_HEIGHT));
    s1_wok   <= (32'(s0_col) < 32'(MAX_SRC_WIDTH)) && (32'(s0_row) < 32'(MAX_SRC_HEIGHT));
    s1_waddr <= AW'(AW'(s0_row) * AW'(MAX_SRC_WIDTH)) + AW'(s0_col);
    s1_pix   <= s0_pix;
    pa <= $signed(coef_ab[63:32]) * xs;
    pb <= $signed(coef_ab[31:0])  * ys;
    pd <= $signed(coef_cd[31:0])  * xs;
    pe <= $signed(coef_ef[63:32]) * ys;
    pg <= $signed(coef_gh[63:32]) * xs;
    ph <= $signed(coef_gh[31:0])  * ys;
  end

  // Stage 2: the three projective sums.
  logic                 s2_v, s2_cmd, s2_dok, s2_wok;
  logic [AW-1:0]        s2_waddr;
  logic [PIX_W-1:0]     s2_pix;
  logic signed [NW-1:0] nx, ny, nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd   <= s1_cmd;
    s2_dok   <= s1_dok;
    s2_wok   <= s1_wok;
    s2_waddr <= s1_waddr;
    s2_pix   <= s1_pix;
    nx <= NW'(pa) + NW'(pb) + NW'($signed(coef_cd[63:32]));
    ny <= NW'(pd) + NW'(pe) + NW'($signed(coef_ef[31:0]));
    nz <= NW'(pg) + NW'(ph) + NW'($signed(coef_i));
  end

  // Divider chain. Entry 0 holds magnitudes and early outside flags; each following
  // entry has tried one more quotient bit. The first step only checks for overflow.
  logic           d_v     [NS+1];
  logic           d_cmd   [NS+1];
  logic           d_wok   [NS+1];
  logic [AW-1:0]  d_waddr [NS+1];
  logic [PIX_W-1:0] d_pix [NS+1];
  logic           d_out   [NS+1];
  logic [RW-1:0]  d_rx    [NS+1];
  logic [RW-1:0]  d_ry    [NS+1];
  logic [MW-1:0]  d_md    [NS+1];
  logic [QB-1:0]  d_qx    [NS+1];
  logic [QB-1:0]  d_qy    [NS+1];

  logic          x_bad, y_bad;
  logic [MW-1:0] mx, my, mz;

  always_comb begin
    x_bad = (nx != '0) && (nx[NW-1] != nz[NW-1]);
    y_bad = (ny != '0) && (ny[NW-1] != nz[NW-1]);
    mx    = nx[NW-1] ? MW'(-nx) : MW'(nx);
    my    = ny[NW-1] ? MW'(-ny) : MW'(ny);
    mz    = nz[NW-1] ? MW'(-nz) : MW'(nz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else begin
      d_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    d_cmd[0]   <= s2_cmd;
    d_wok[0]   <= s2_wok;
    d_waddr[0] <= s2_waddr;
    d_pix[0]   <= s2_pix;
    d_out[0]   <= !s2_dok || (nz == '0) || x_bad || y_bad;
    d_rx[0]    <= RW'(mx) << FRAC_SHIFT;
    d_ry[0]    <= RW'(my) << FRAC_SHIFT;
    d_md[0]    <= mz;
    d_qx[0]    <= '0;
    d_qy[0]    <= '0;
  end

  for (genvar j = 0; j < NS; j++) begin : g_div
    localparam int unsigned SH = QB - j;
    logic [RW-1:0] dshift;
    logic          ge_x, ge_y;

    assign dshift = RW'(d_md[j]) << SH;
    assign ge_x   = d_rx[j] >= dshift;
    assign ge_y   = d_ry[j] >= dshift;

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[j+1] <= 1'b0;
      end else begin
        d_v[j+1] <= d_v[j];
      end
    end

    always_ff @(posedge clk) begin
      d_cmd[j+1]   <= d_cmd[j];
      d_wok[j+1]   <= d_wok[j];
      d_waddr[j+1] <= d_waddr[j];
      d_pix[j+1]   <= d_pix[j];
      d_md[j+1]    <= d_md[j];
      d_rx[j+1]    <= ge_x ? d_rx[j] - dshift : d_rx[j];
      d_ry[j+1]    <= ge_y ? d_ry[j] - dshift : d_ry[j];
      if (j == 0) begin
        // A quotient of 2^QB or more lies beyond any permitted frame size.
        d_out[j+1] <= d_out[j] || ge_x || ge_y;
        d_qx[j+1]  <= d_qx[j];
        d_qy[j+1]  <= d_qy[j];
      end else begin
        d_out[j+1] <= d_out[j];
        d_qx[j+1]  <= (d_qx[j] << 1) | QB'(ge_x);
        d_qy[j+1]  <= (d_qy[j] << 1) | QB'(ge_y);
      end
    end
  end

  // Bounds check and frame store access.
  logic [QB-1:0] wlim, hlim;
  logic          in_frame, ram_we;
  logic [AW-1:0] raddr;
  logic [PIX_W-1:0] rdata;
  logic          e_v, e_in;

  always_comb begin
    wlim = (32'(src_w) > 32'(MAX_SRC_WIDTH))  ? QB'(MAX_SRC_WIDTH)  : QB'(src_w);
    hlim = (32'(src_h) > 32'(MAX_SRC_HEIGHT)) ? QB'(MAX_SRC_HEIGHT) : QB'(src_h);
    in_frame = !d_out[NS] && (d_qx[NS] < wlim) && (d_qy[NS] < hlim);
    raddr    = AW'(AW'(d_qy[NS]) * AW'(MAX_SRC_WIDTH)) + AW'(d_qx[NS]);
    ram_we   = d_v[NS] && (cmd_t'(d_cmd[NS]) == CMD_WRITE) && d_wok[NS];
  end

  pwf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (d_waddr[NS]),
    .wdata (d_pix[NS]),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= d_v[NS] && (cmd_t'(d_cmd[NS]) == CMD_WARP);
    end
  end

  always_ff @(posedge clk) begin
    e_in <= in_frame;
  end

  assign strobe     = e_v;
  assign inside_res = e_v && e_in;
  assign pixel_out  = e_in ? rdata : fill;

  // Every result word traces back to an accepted warp word.
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy && (cmd == CMD_WARP), LAT))
    else $error("result strobe without a matching warp word");

  // A write word never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy && (cmd == CMD_WRITE), LAT) |-> !strobe)
    else $error("result strobe caused by a write word");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !strobe && !s0_v)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
